### sv/assert_macros.svh
// assertion macros for the checker file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// antecedent true implies consequent in the same cycle
`define ASSERT_SAME(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed: same-cycle implication");

// antecedent true implies consequent in the next cycle
`define ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed: next-cycle implication");

`endif

### sv/see_pkg.sv
// shared types, codes and constants of the stack expression evaluator
`default_nettype none

package see_pkg;

   localparam int STACK_DEPTH = 64;
   localparam int ADDR_W      = $clog2(STACK_DEPTH);
   localparam int CNT_W       = $clog2(STACK_DEPTH + 1);
   localparam int DATA_W      = 32;
   localparam int ACTION_W    = 3;
   localparam int MODE_W      = 2;
   localparam int ERR_W       = 2;
   localparam int QUEUE_DEPTH = 2;
   localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
   localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

   // token kinds
   localparam logic [ACTION_W-1:0] ACT_NUMBER = 3'd0;
   localparam logic [ACTION_W-1:0] ACT_ADD    = 3'd1;
   localparam logic [ACTION_W-1:0] ACT_SUB    = 3'd2;
   localparam logic [ACTION_W-1:0] ACT_MUL    = 3'd3;
   localparam logic [ACTION_W-1:0] ACT_DIV    = 3'd4;
   localparam logic [ACTION_W-1:0] ACT_OPEN   = 3'd5;
   localparam logic [ACTION_W-1:0] ACT_CLOSE  = 3'd6;

   // modes
   localparam logic [MODE_W-1:0] MODE_POSTFIX = 2'd0;
   localparam logic [MODE_W-1:0] MODE_PREFIX  = 2'd1;
   localparam int                MODE_BALANCE_BIT = 1;

   // sticky error codes
   localparam logic [ERR_W-1:0] ERR_NONE      = 2'd0;
   localparam logic [ERR_W-1:0] ERR_UNDERFLOW = 2'd1;
   localparam logic [ERR_W-1:0] ERR_DIV_ZERO  = 2'd2;
   localparam logic [ERR_W-1:0] ERR_FULL      = 2'd3;

   typedef enum logic [1:0] {
      CMD_NOP,
      CMD_PUSH,
      CMD_POP,
      CMD_BINOP
   } cmd_kind_type;

   typedef enum logic [1:0] {
      ALU_ADD,
      ALU_SUB,
      ALU_MUL,
      ALU_DIV
   } alu_op_type;

   typedef struct packed {
      cmd_kind_type        kind;
      alu_op_type          op;
      logic                swap;     // prefix: first pop is the left operand
      logic                balance;
      logic                last;
      logic [DATA_W-1:0]   value;
   } cmd_type;

   typedef enum logic [3:0] {
      BACK_IDLE,
      BACK_POP1,
      BACK_GET1,
      BACK_POP2,
      BACK_GET2,
      BACK_EXEC,
      BACK_DIV,
      BACK_PUSH,
      BACK_DONE
   } back_state_type;

endpackage

`default_nettype wire

### sv/see_ifs.sv
// request and response channel interfaces
`default_nettype none

interface see_req_if import see_pkg::*;;
   logic                       valid;
   logic                       ready;
   logic [ACTION_W-1:0]        action;
   logic signed [DATA_W-1:0]   operand_value;
   logic                       last;

   modport source (output valid, action, operand_value, last, input ready);
   modport sink   (input valid, action, operand_value, last, output ready);
endinterface

interface see_rsp_if import see_pkg::*;;
   logic                       valid;
   logic                       ready;
   logic                       done_res;
   logic                       valid_res;
   logic signed [DATA_W-1:0]   value;
   logic [ERR_W-1:0]           error_code;

   modport source (output valid, done_res, valid_res, value, error_code, input ready);
   modport sink   (input valid, done_res, valid_res, value, error_code, output ready);
endinterface

`default_nettype wire

### sv/see_ram.sv
// generic single-port-write, single-port-read ram with registered read
`default_nettype none

module see_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 64
) (
   input  wire logic                     clock,
   input  wire logic                     write_enable,
   input  wire logic [$clog2(DEPTH)-1:0] write_address,
   input  wire logic [WIDTH-1:0]         write_data,
   input  wire logic                     read_enable,
   input  wire logic [$clog2(DEPTH)-1:0] read_address,
   output      logic [WIDTH-1:0]         read_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] read_data_ff;

   always_ff @(posedge clock) begin
      if (write_enable) begin
         mem_ff[write_address] <= write_data;
      end
      if (read_enable) begin
         read_data_ff <= mem_ff[read_address];
      end
   end

   assign read_data = read_data_ff;

endmodule

`default_nettype wire

### sv/see_div.sv
// iterative signed divider, one quotient bit per cycle, truncates toward zero
`default_nettype none

module see_div import see_pkg::*; (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              start,
   input  wire logic [DATA_W-1:0] dividend,
   input  wire logic [DATA_W-1:0] divisor,
   output      logic              done,
   output      logic [DATA_W-1:0] quotient
);

   localparam int STEP_W = $clog2(DATA_W);

   logic              busy_ff, busy_in;
   logic              done_ff, done_in;
   logic [STEP_W-1:0] step_ff, step_in;
   logic [DATA_W:0]   rem_ff, rem_in;
   logic [DATA_W-1:0] quo_ff, quo_in;
   logic [DATA_W-1:0] dmag_ff, dmag_in;
   logic              neg_ff, neg_in;

   logic [DATA_W:0]   shifted;
   logic [DATA_W:0]   trial;

   assign shifted = {rem_ff[DATA_W-1:0], quo_ff[DATA_W-1]};
   assign trial   = shifted - {1'b0, dmag_ff};

   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      step_in = step_ff;
      rem_in  = rem_ff;
      quo_in  = quo_ff;
      dmag_in = dmag_ff;
      neg_in  = neg_ff;
      if (start) begin
         busy_in = 1'b1;
         step_in = '0;
         rem_in  = '0;
         // magnitudes; the most negative value maps to itself as unsigned
         quo_in  = dividend[DATA_W-1] ? (~dividend + DATA_W'(1)) : dividend;
         dmag_in = divisor[DATA_W-1] ? (~divisor + DATA_W'(1)) : divisor;
         neg_in  = dividend[DATA_W-1] ^ divisor[DATA_W-1];
      end else if (busy_ff) begin
         if (!trial[DATA_W]) begin
            rem_in = trial;
            quo_in = {quo_ff[DATA_W-2:0], 1'b1};
         end else begin
            rem_in = shifted;
            quo_in = {quo_ff[DATA_W-2:0], 1'b0};
         end
         step_in = step_ff + STEP_W'(1);
         if (step_ff == STEP_W'(DATA_W - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         step_ff <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         step_ff <= step_in;
      end
      rem_ff  <= rem_in;
      quo_ff  <= quo_in;
      dmag_ff <= dmag_in;
      neg_ff  <= neg_in;
   end

   assign done     = done_ff;
   assign quotient = neg_ff ? (~quo_ff + DATA_W'(1)) : quo_ff;

endmodule

`default_nettype wire

### sv/see_queue.sv
// short command queue between the front and back parts
`default_nettype none

module see_queue import see_pkg::*; (
   input  wire logic    clock,
   input  wire logic    reset,
   input  wire logic    push,
   input  wire cmd_type push_cmd,
   output      logic    full,
   input  wire logic    pop,
   output      cmd_type head_cmd,
   output      logic    not_empty
);

   cmd_type             entries_ff [QUEUE_DEPTH];
   logic [QPTR_W-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [QPTR_W-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [QCNT_W-1:0]   count_ff, count_in;

   function automatic logic [QPTR_W-1:0] next_ptr(input logic [QPTR_W-1:0] ptr);
      next_ptr = (ptr == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : ptr + QPTR_W'(1);
   endfunction

   always_comb begin
      wr_ptr_in = push ? next_ptr(wr_ptr_ff) : wr_ptr_ff;
      rd_ptr_in = pop  ? next_ptr(rd_ptr_ff) : rd_ptr_ff;
      count_in  = count_ff;
      if (push && !pop) begin
         count_in = count_ff + QCNT_W'(1);
      end else if (pop && !push) begin
         count_in = count_ff - QCNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
      if (push) begin
         entries_ff[wr_ptr_ff] <= push_cmd;
      end
   end

   assign full      = (count_ff == QCNT_W'(QUEUE_DEPTH));
   assign not_empty = (count_ff != '0);
   assign head_cmd  = entries_ff[rd_ptr_ff];

endmodule

`default_nettype wire

### sv/see_front.sv
// front part: mode register, request accept and token classification
`default_nettype none

module see_front import see_pkg::*; (
   input  wire logic              clock,
   input  wire logic              reset,
   see_req_if.sink                req_ch,
   input  wire logic              csr_write_enable,
   input  wire logic [MODE_W-1:0] csr_write_data,
   input  wire logic              queue_full,
   output      logic              queue_push,
   output      cmd_type           queue_cmd
);

   logic [MODE_W-1:0] mode_ff, mode_in;
   logic              balance;

   assign mode_in = csr_write_enable ? csr_write_data : mode_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff <= MODE_POSTFIX;
      end else begin
         mode_ff <= mode_in;
      end
   end

   assign req_ch.ready = !queue_full;
   assign queue_push   = req_ch.valid && !queue_full;
   assign balance      = mode_ff[MODE_BALANCE_BIT];

   always_comb begin
      queue_cmd.kind    = CMD_NOP;
      queue_cmd.op      = ALU_ADD;
      queue_cmd.swap    = (mode_ff == MODE_PREFIX);
      queue_cmd.balance = balance;
      queue_cmd.last    = req_ch.last;
      queue_cmd.value   = req_ch.operand_value;
      if (balance) begin
         // only parentheses count; an open paren pushes a marker
         unique case (req_ch.action)
            ACT_OPEN: begin
               queue_cmd.kind  = CMD_PUSH;
               queue_cmd.value = DATA_W'(1);
            end
            ACT_CLOSE: queue_cmd.kind = CMD_POP;
            default:   queue_cmd.kind = CMD_NOP;
         endcase
      end else begin
         unique case (req_ch.action)
            ACT_NUMBER: queue_cmd.kind = CMD_PUSH;
            ACT_ADD: begin
               queue_cmd.kind = CMD_BINOP;
               queue_cmd.op   = ALU_ADD;
            end
            ACT_SUB: begin
               queue_cmd.kind = CMD_BINOP;
               queue_cmd.op   = ALU_SUB;
            end
            ACT_MUL: begin
               queue_cmd.kind = CMD_BINOP;
               queue_cmd.op   = ALU_MUL;
            end
            ACT_DIV: begin
               queue_cmd.kind = CMD_BINOP;
               queue_cmd.op   = ALU_DIV;
            end
            default: queue_cmd.kind = CMD_NOP;
         endcase
      end
   end

endmodule

`default_nettype wire

### sv/see_back.sv
// back part: stack sequencer, operand stack ram, alu and response register
`default_nettype none

module see_back import see_pkg::*; (
   input  wire logic    clock,
   input  wire logic    reset,
   input  wire logic    queue_not_empty,
   input  wire cmd_type queue_cmd,
   output      logic    queue_pop,
   see_rsp_if.source    rsp_ch
);

   back_state_type    state_ff, state_in;
   logic [CNT_W-1:0]  cnt_ff, cnt_in;
   logic [ERR_W-1:0]  err_ff, err_in;
   cmd_type           cmd_ff, cmd_in;
   logic [DATA_W-1:0] first_ff, first_in;
   logic [DATA_W-1:0] second_ff, second_in;
   logic [DATA_W-1:0] result_ff, result_in;
   logic [DATA_W-1:0] bottom_ff, bottom_in;   // copy of stack entry zero

   logic              rsp_valid_ff, rsp_valid_in;
   logic              rsp_done_ff, rsp_done_in;
   logic              rsp_ok_ff, rsp_ok_in;
   logic [DATA_W-1:0] rsp_value_ff, rsp_value_in;
   logic [ERR_W-1:0]  rsp_err_ff, rsp_err_in;

   logic              ram_we;
   logic [ADDR_W-1:0] ram_waddr;
   logic              ram_re;
   logic [ADDR_W-1:0] ram_raddr;
   logic [DATA_W-1:0] ram_rdata;

   logic              div_start;
   logic              div_done;
   logic [DATA_W-1:0] div_quotient;

   logic [DATA_W-1:0]   lhs;
   logic [DATA_W-1:0]   rhs;
   logic [DATA_W-1:0]   product;
   logic [CNT_W-1:0]    cnt_dec;
   logic                out_free;
   logic                final_ok;

   see_ram #(
      .WIDTH(DATA_W),
      .DEPTH(STACK_DEPTH)
   ) u_stack_ram (
      .clock        (clock),
      .write_enable (ram_we),
      .write_address(ram_waddr),
      .write_data   (result_ff),
      .read_enable  (ram_re),
      .read_address (ram_raddr),
      .read_data    (ram_rdata)
   );

   see_div u_div (
      .clock   (clock),
      .reset   (reset),
      .start   (div_start),
      .dividend(lhs),
      .divisor (rhs),
      .done    (div_done),
      .quotient(div_quotient)
   );

   function automatic logic [ERR_W-1:0] sticky(input logic [ERR_W-1:0] cur,
                                               input logic [ERR_W-1:0] code);
      sticky = (cur == ERR_NONE) ? code : cur;
   endfunction

   assign lhs       = cmd_ff.swap ? first_ff : second_ff;
   assign rhs       = cmd_ff.swap ? second_ff : first_ff;
   assign product   = lhs * rhs;
   assign cnt_dec   = cnt_ff - CNT_W'(1);
   assign ram_raddr = cnt_dec[ADDR_W-1:0];
   assign ram_waddr = cnt_ff[ADDR_W-1:0];
   assign out_free  = !rsp_valid_ff || rsp_ch.ready;
   assign final_ok  = (err_ff == ERR_NONE) &&
                      (cmd_ff.balance ? (cnt_ff == '0) : (cnt_ff == CNT_W'(1)));

   always_comb begin
      state_in     = state_ff;
      cnt_in       = cnt_ff;
      err_in       = err_ff;
      cmd_in       = cmd_ff;
      first_in     = first_ff;
      second_in    = second_ff;
      result_in    = result_ff;
      bottom_in    = bottom_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ch.ready;
      rsp_done_in  = rsp_done_ff;
      rsp_ok_in    = rsp_ok_ff;
      rsp_value_in = rsp_value_ff;
      rsp_err_in   = rsp_err_ff;
      ram_we       = 1'b0;
      ram_re       = 1'b0;
      div_start    = 1'b0;
      queue_pop    = 1'b0;

      unique case (state_ff)
         BACK_IDLE: begin
            if (queue_not_empty) begin
               queue_pop = 1'b1;
               cmd_in    = queue_cmd;
               unique case (queue_cmd.kind)
                  CMD_PUSH: begin
                     result_in = queue_cmd.value;
                     state_in  = BACK_PUSH;
                  end
                  CMD_POP: begin
                     if (cnt_ff == '0) begin
                        err_in = sticky(err_ff, ERR_UNDERFLOW);
                     end else begin
                        cnt_in = cnt_dec;
                     end
                     state_in = BACK_DONE;
                  end
                  CMD_BINOP: state_in = BACK_POP1;
                  CMD_NOP:   state_in = BACK_DONE;
               endcase
            end
         end
         BACK_POP1: begin
            if (cnt_ff == '0) begin
               first_in = '0;
               err_in   = sticky(err_ff, ERR_UNDERFLOW);
               state_in = BACK_POP2;
            end else begin
               ram_re   = 1'b1;
               cnt_in   = cnt_dec;
               state_in = BACK_GET1;
            end
         end
         BACK_GET1: begin
            first_in = ram_rdata;
            state_in = BACK_POP2;
         end
         BACK_POP2: begin
            if (cnt_ff == '0) begin
               second_in = '0;
               err_in    = sticky(err_ff, ERR_UNDERFLOW);
               state_in  = BACK_EXEC;
            end else begin
               ram_re   = 1'b1;
               cnt_in   = cnt_dec;
               state_in = BACK_GET2;
            end
         end
         BACK_GET2: begin
            second_in = ram_rdata;
            state_in  = BACK_EXEC;
         end
         BACK_EXEC: begin
            state_in = BACK_PUSH;
            unique case (cmd_ff.op)
               ALU_ADD: result_in = lhs + rhs;
               ALU_SUB: result_in = lhs - rhs;
               ALU_MUL: result_in = product;
               ALU_DIV: begin
                  if (rhs == '0) begin
                     result_in = '0;
                     err_in    = sticky(err_ff, ERR_DIV_ZERO);
                  end else begin
                     div_start = 1'b1;
                     state_in  = BACK_DIV;
                  end
               end
            endcase
         end
         BACK_DIV: begin
            if (div_done) begin
               result_in = div_quotient;
               state_in  = BACK_PUSH;
            end
         end
         BACK_PUSH: begin
            if (cnt_ff >= CNT_W'(STACK_DEPTH)) begin
               err_in = sticky(err_ff, ERR_FULL);
            end else begin
               ram_we = 1'b1;
               cnt_in = cnt_ff + CNT_W'(1);
               if (cnt_ff == '0) begin
                  bottom_in = result_ff;
               end
            end
            state_in = BACK_DONE;
         end
         BACK_DONE: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_done_in  = cmd_ff.last;
               rsp_ok_in    = cmd_ff.last && final_ok;
               rsp_value_in = (cmd_ff.last && final_ok && !cmd_ff.balance) ?
                              bottom_ff : '0;
               rsp_err_in   = err_ff;
               if (cmd_ff.last) begin
                  cnt_in = '0;
                  err_in = ERR_NONE;
               end
               state_in = BACK_IDLE;
            end
         end
         default: state_in = BACK_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= BACK_IDLE;
         cnt_ff       <= '0;
         err_ff       <= ERR_NONE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         cnt_ff       <= cnt_in;
         err_ff       <= err_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      cmd_ff       <= cmd_in;
      first_ff     <= first_in;
      second_ff    <= second_in;
      result_ff    <= result_in;
      bottom_ff    <= bottom_in;
      rsp_done_ff  <= rsp_done_in;
      rsp_ok_ff    <= rsp_ok_in;
      rsp_value_ff <= rsp_value_in;
      rsp_err_ff   <= rsp_err_in;
   end

   assign rsp_ch.valid      = rsp_valid_ff;
   assign rsp_ch.done_res   = rsp_done_ff;
   assign rsp_ch.valid_res  = rsp_ok_ff;
   assign rsp_ch.value      = rsp_value_ff;
   assign rsp_ch.error_code = rsp_err_ff;

endmodule

`default_nettype wire

### sv/stack_expression_evaluator.sv
// top level of the stack expression evaluator
//
// usage
//   req_ch carries one token per request: action, operand_value and last.
//   rsp_ch returns one response per request, in order: done_res, valid_res,
//   value and the sticky error_code after that token. csr_write_* sets the
//   mode (postfix, prefix, balance); the user must write it only while no
//   request is in flight, as the block itself does not enforce this. it
//   applies from the next token on and the stack is kept across the change.
// sequencing
//   the back sequencer runs one token at a time. a close paren or an ignored
//   token goes straight to the response; a number or open paren is pushed
//   first; add, subtract, multiply and divide by zero take two registered
//   stack reads, skipping each that pops an empty stack, then the alu and a
//   push; a divide also waits for the one-bit-per-cycle divider over 32
//   quotient bits. a two-entry queue lets the request side run up to two tokens ahead.
// reset: synchronous, active high; empties the queue, the stack count and
//   the sticky error and sets postfix mode. stack ram is not cleared.
// backpressure: a response waits in the output register while rsp_ch.ready
//   is low; the queue fills behind it, then req_ch.ready drops.
`default_nettype none

module stack_expression_evaluator import see_pkg::*; (
   input  wire logic              clock,
   input  wire logic              reset,
   see_req_if.sink                req_ch,
   see_rsp_if.source              rsp_ch,
   input  wire logic              csr_write_enable,
   input  wire logic [MODE_W-1:0] csr_write_data
);

   // front to queue
   logic    push;
   cmd_type push_cmd;
   logic    full;

   // queue to back
   logic    pop;
   cmd_type head_cmd;
   logic    not_empty;

   // token classification and mode register
   see_front u_front (
      .clock           (clock),
      .reset           (reset),
      .req_ch          (req_ch),
      .csr_write_enable(csr_write_enable),
      .csr_write_data  (csr_write_data),
      .queue_full      (full),
      .queue_push      (push),
      .queue_cmd       (push_cmd)
   );

   // decouples request accept from execution
   see_queue u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (push),
      .push_cmd (push_cmd),
      .full     (full),
      .pop      (pop),
      .head_cmd (head_cmd),
      .not_empty(not_empty)
   );

   // stack execution and response register
   see_back u_back (
      .clock          (clock),
      .reset          (reset),
      .queue_not_empty(not_empty),
      .queue_cmd      (head_cmd),
      .queue_pop      (pop),
      .rsp_ch         (rsp_ch)
   );

endmodule

`default_nettype wire

### sv/see_checker.sv
// port-level checker for the stack expression evaluator and its bind
`default_nettype none

`include "assert_macros.svh"

module see_checker import see_pkg::*; (
   input wire logic              clock,
   input wire logic              reset,
   input wire logic              rsp_valid,
   input wire logic              rsp_ready,
   input wire logic              rsp_done_res,
   input wire logic              rsp_valid_res,
   input wire logic [DATA_W-1:0] rsp_value,
   input wire logic [ERR_W-1:0]  rsp_error_code
);

   logic                    rsp_stall;
   logic                    rsp_ok;
   logic                    rsp_nonzero;
   logic [DATA_W+ERR_W+1:0] rsp_payload;

   assign rsp_stall   = rsp_valid && !rsp_ready;
   assign rsp_ok      = rsp_valid && rsp_valid_res;
   assign rsp_nonzero = rsp_valid && (rsp_value != '0);
   assign rsp_payload = {rsp_done_res, rsp_valid_res, rsp_value, rsp_error_code};

   // a stalled response keeps its contents
   `ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_stall, rsp_valid && $stable(rsp_payload))

   // validity is only reported when an expression closes
   `ASSERT_SAME(a_valid_needs_done, clock, reset, rsp_ok, rsp_done_res)

   // a valid expression never carries an error
   `ASSERT_SAME(a_valid_no_error, clock, reset, rsp_ok, rsp_error_code == ERR_NONE)

   // a nonzero value only comes with a valid closing response
   `ASSERT_SAME(a_value_gated, clock, reset, rsp_nonzero, rsp_done_res && rsp_valid_res)

   // reset empties the response register
   `ASSERT_NEXT(a_reset_clears, clock, 1'b0, reset, !rsp_valid)

endmodule

bind stack_expression_evaluator see_checker u_see_checker (
   .clock         (clock),
   .reset         (reset),
   .rsp_valid     (rsp_ch.valid),
   .rsp_ready     (rsp_ch.ready),
   .rsp_done_res  (rsp_ch.done_res),
   .rsp_valid_res (rsp_ch.valid_res),
   .rsp_value     (rsp_ch.value),
   .rsp_error_code(rsp_ch.error_code)
);

`default_nettype wire
